[rtl/core/bmhq_pkg.sv]
// shared types, constants and helpers for the binary max-heap queue
// no dependencies; imported by bmhq_ram, binary_max_heap_queue and the testbench
package bmhq_pkg;

   localparam int DEPTH  = 1024;
   localparam int AW     = $clog2(DEPTH);
   localparam int PW     = 11;
   localparam int CW     = PW + 1;
   localparam int DW     = 32;

   typedef enum logic [1:0] {
      MODE_INSERT  = 2'd0,
      MODE_EXTRACT = 2'd1,
      MODE_REMOVE  = 2'd2,
      MODE_CHANGE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_BADIX = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [PW-1:0]     slot;
      logic signed [DW-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] taken_value;
      logic [1:0]        status;
      logic [PW-1:0]     count;
   } rsp_type;

   // one-based heap position to memory address
   function automatic logic [AW-1:0] pos2addr(input logic [PW-1:0] pos);
      logic [PW-1:0] t;
      t = pos - PW'(1);
      return t[AW-1:0];
   endfunction

endpackage

[rtl/core/binary_max_heap_queue.sv]
// binary max-heap priority queue, top level: sequencer around the heap memory
// depends on bmhq_pkg and bmhq_ram
//
//   channel   direction  handshake          payload
//   req       in         req_valid/stall    req_type  (mode, slot, priority_req)
//   rsp       out        rsp_valid/stall    rsp_type  (taken_value, status, count)
//
// one transaction at a time; a sift walks the tree through the single read port
// insert sifts up; change sifts up or down; remove shifts the path above the slot
// down, then extract and remove sift down from the root; rejected requests go
// straight to the response state; sift down costs two reads per level
// reset clears the count and control only; heap memory needs no clearing
// rsp stall holds the result register and the sequencer waits in its last state
module binary_max_heap_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bmhq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bmhq_pkg::rsp_type rsp_payload
);
   import bmhq_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_TAKE   = 12'b000000000010,  // capture value leaving, start path shift
      S_SHIFT  = 12'b000000000100,  // move ancestors down one level
      S_LAST   = 12'b000000001000,  // read last entry
      S_LASTD  = 12'b000000010000,
      S_CHG    = 12'b000000100000,  // old value arrives
      S_UP     = 12'b000001000000,
      S_UPC    = 12'b000010000000,
      S_DN     = 12'b000100000000,
      S_DNL    = 12'b001000000000,
      S_DNR    = 12'b010000000000,
      S_RESP   = 12'b100000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [PW-1:0]        cnt_ff, cnt_in;
   logic [PW-1:0]        p_ff, p_in;
   logic signed [DW-1:0] v_ff, v_in;        // value being sifted
   logic signed [DW-1:0] lval_ff, lval_in;  // left child value
   logic signed [DW-1:0] taken_ff, taken_in;
   status_type           stat_ff, stat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic signed [DW-1:0] wr_data, rd_data;

   logic                 accept;
   logic [PW-1:0]        par, gpar;
   logic [CW-1:0]        lpos, rpos, cnt_w, nl;
   logic [PW-1:0]        best;
   logic signed [DW-1:0] bestv;

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign par   = p_ff >> 1;
   assign gpar  = p_ff >> 2;
   assign lpos  = {p_ff, 1'b0};
   assign rpos  = {p_ff, 1'b1};
   assign cnt_w = {1'b0, cnt_ff};

   bmhq_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // best of hole value and its children
   always_comb begin
      best  = p_ff;
      bestv = v_ff;
      if (lval_ff > v_ff) begin
         best  = lpos[PW-1:0];
         bestv = lval_ff;
      end
      if ((rpos <= cnt_w) && (rd_data > bestv)) begin
         best  = rpos[PW-1:0];
         bestv = rd_data;
      end
      nl = {best, 1'b0};
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      p_in         = p_ff;
      v_in         = v_ff;
      lval_in      = lval_ff;
      taken_in     = taken_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pos2addr(p_ff);
      wr_data      = v_ff;
      rd_en        = 1'b0;
      rd_addr      = pos2addr(par);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               taken_in = '0;
               stat_in  = ST_OK;
               v_in     = req_payload.priority_req;
               p_in     = req_payload.slot;
               state_in = S_RESP;
               unique case (mode_type'(req_payload.mode))
                  MODE_INSERT: begin
                     if (cnt_ff >= PW'(DEPTH)) begin
                        stat_in = ST_FULL;
                     end else begin
                        cnt_in   = cnt_ff + PW'(1);
                        p_in     = cnt_ff + PW'(1);
                        state_in = S_UP;
                     end
                  end
                  MODE_EXTRACT: begin
                     if (cnt_ff == '0) begin
                        stat_in = ST_EMPTY;
                     end else begin
                        p_in     = PW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_TAKE;
                     end
                  end
                  default: begin
                     if (req_payload.slot == '0 || req_payload.slot > cnt_ff) begin
                        stat_in = ST_BADIX;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = pos2addr(req_payload.slot);
                        state_in = (mode_type'(req_payload.mode) == MODE_REMOVE)
                                   ? S_TAKE : S_CHG;
                     end
                  end
               endcase
            end
         end
         S_TAKE: begin
            taken_in = rd_data;
            if (p_ff == PW'(1)) begin
               state_in = S_LAST;
            end else begin
               rd_en    = 1'b1;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // parent value drops into the hole, root is overwritten later
            wr_en   = 1'b1;
            wr_data = rd_data;
            p_in    = par;
            if (par == PW'(1)) begin
               state_in = S_LAST;
            end else begin
               rd_en   = 1'b1;
               rd_addr = pos2addr(gpar);
            end
         end
         S_LAST: begin
            rd_en    = 1'b1;
            rd_addr  = pos2addr(cnt_ff);
            state_in = S_LASTD;
         end
         S_LASTD: begin
            v_in     = rd_data;
            cnt_in   = cnt_ff - PW'(1);
            p_in     = PW'(1);
            state_in = S_DN;
         end
         S_CHG: begin
            state_in = (v_ff > rd_data) ? S_UP : S_DN;
         end
         S_UP: begin
            if (p_ff == PW'(1)) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               state_in = S_UPC;
            end
         end
         S_UPC: begin
            wr_en = 1'b1;
            if (rd_data < v_ff) begin
               wr_data = rd_data;
               p_in    = par;
               if (par == PW'(1)) begin
                  state_in = S_UP;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos2addr(gpar);
               end
            end else begin
               state_in = S_RESP;
            end
         end
         S_DN: begin
            if (lpos > cnt_w) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = pos2addr(lpos[PW-1:0]);
               state_in = S_DNL;
            end
         end
         S_DNL: begin
            lval_in  = rd_data;
            rd_en    = 1'b1;
            rd_addr  = pos2addr(rpos[PW-1:0]);
            state_in = S_DNR;
         end
         S_DNR: begin
            wr_en = 1'b1;
            if (best == p_ff) begin
               state_in = S_RESP;
            end else begin
               wr_data = bestv;
               p_in    = best;
               if (nl > cnt_w) begin
                  state_in = S_DN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = pos2addr(nl[PW-1:0]);
                  state_in = S_DNL;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.taken_value = taken_ff;
               rsp_in.status      = stat_ff;
               rsp_in.count       = cnt_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      v_ff     <= v_in;
      lval_ff  <= lval_in;
      taken_ff <= taken_in;
      stat_ff  <= stat_in;
      rsp_ff   <= rsp_in;
   end

   // count never passes capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= PW'(DEPTH))
      else $error("entry count above capacity");

   // memory is written only while a transaction is in flight
   a_wr_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != S_IDLE))
      else $error("heap write while idle");

   // an accepted transaction leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after accept");

   // result register loads only from the response state
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || !rsp_stall) && (state_ff != S_RESP) |=> !rsp_valid_ff)
      else $error("result appeared without response state");

endmodule

[rtl/core/bmhq_ram.sv]
// heap storage: one write port, one read port, registered read data
// depends on bmhq_pkg
module bmhq_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [bmhq_pkg::AW-1:0]      wr_addr,
   input  logic signed [bmhq_pkg::DW-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [bmhq_pkg::AW-1:0]      rd_addr,
   output logic signed [bmhq_pkg::DW-1:0] rd_data
);
   import bmhq_pkg::*;

   logic signed [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[tb/sv/binary_max_heap_queue_tb.sv]
// self-checking testbench for the binary max-heap queue
// depends on bmhq_pkg and binary_max_heap_queue; predicts each result with its own heap copy
module binary_max_heap_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bmhq_pkg::*;

   localparam int CAP = 1024;
   localparam int CYCLE_LIMIT = 900000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   binary_max_heap_queue dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // shadow heap, one-based positions held at index p-1
   logic signed [31:0] shadow_heap [CAP];
   int unsigned        shadow_count = 0;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      stim_done = 1'b0;
   bit      hold_start = 1'b0;   // asks for the long receiver hold-off
   bit      hold_used = 1'b0;
   int      hold_off = 0;        // long receiver hold-off, in cycles

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic signed [31:0] t;
      t = shadow_heap[a-1];
      shadow_heap[a-1] = shadow_heap[b-1];
      shadow_heap[b-1] = t;
   endfunction

   function automatic void bubble_up(int unsigned p);
      while (p > 1 && shadow_heap[(p>>1)-1] < shadow_heap[p-1]) begin
         swap_slots(p >> 1, p);
         p = p >> 1;
      end
   endfunction

   function automatic void bubble_down(int unsigned p);
      int unsigned best, l, r;
      forever begin
         best = p;
         l = 2 * p;
         r = l + 1;
         if (l <= shadow_count && shadow_heap[l-1] > shadow_heap[best-1]) best = l;
         if (r <= shadow_count && shadow_heap[r-1] > shadow_heap[best-1]) best = r;
         if (best == p) break;
         swap_slots(p, best);
         p = best;
      end
   endfunction

   function automatic logic signed [31:0] pop_root();
      logic signed [31:0] top;
      top = shadow_heap[0];
      shadow_heap[0] = shadow_heap[shadow_count-1];
      shadow_count--;
      bubble_down(1);
      return top;
   endfunction

   // expected answer for one request, updating the shadow heap
   function automatic rsp_type heap_answer(input req_type rq);
      rsp_type            rs;
      logic signed [31:0] old;
      int unsigned        p;
      rs = '0;
      rs.status = ST_OK;
      case (mode_type'(rq.mode))
         MODE_INSERT: begin
            if (shadow_count >= CAP) rs.status = ST_FULL;
            else begin
               shadow_count++;
               shadow_heap[shadow_count-1] = rq.priority_req;
               bubble_up(shadow_count);
            end
         end
         MODE_EXTRACT: begin
            if (shadow_count == 0) rs.status = ST_EMPTY;
            else rs.taken_value = pop_root();
         end
         default: begin
            if (rq.slot == 0 || rq.slot > shadow_count) rs.status = ST_BADIX;
            else if (rq.mode == MODE_REMOVE) begin
               p = rq.slot;
               while (p > 1) begin
                  swap_slots(p >> 1, p);
                  p = p >> 1;
               end
               rs.taken_value = pop_root();
            end else begin
               old = shadow_heap[rq.slot-1];
               shadow_heap[rq.slot-1] = rq.priority_req;
               if (rq.priority_req > old) bubble_up(rq.slot);
               else bubble_down(rq.slot);
            end
         end
      endcase
      rs.count = shadow_count[PW-1:0];
      return rs;
   endfunction

   // driver: offers queued transactions, back-to-back or after a random gap
   int   send_gap = 0;
   logic req_taken;
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall && !reset;
      if (req_valid && !req_stall && !reset)
         expected_rsps.push_back(heap_answer(req_payload));
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled: hold payload
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (req_valid && req_taken && pending_reqs.size() > 0
                   && $urandom_range(0, 2) != 0) begin
         // back-to-back: valid stays high, new payload
         req_payload <= pending_reqs.pop_front();
      end else if (!req_valid && pending_reqs.size() > 0) begin
         req_valid <= 1'b1;
         req_payload <= pending_reqs.pop_front();
      end else begin
         req_valid <= 1'b0;
         if (req_taken) send_gap <= $urandom_range(0, 6);
      end
   end

   // monitor and receiver stall
   int rsp_wait = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("unexpected result transaction at cycle %0d", cycle_count);
            error_count++;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_payload.taken_value !== e.taken_value)
               report_mismatch("taken_value", rsp_payload.taken_value, e.taken_value);
            if (rsp_payload.status !== e.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(e.status));
            if (rsp_payload.count !== e.count)
               report_mismatch("count", 32'(rsp_payload.count), 32'(e.count));
         end
      end
   end

   // long hold-off counter, started once on request
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end else if (hold_start && !hold_used) begin
         hold_off <= 400;
         hold_used <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off > 0) begin
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_valid && !rsp_stall)
            rsp_wait <= stim_done ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
      end
   end

   function automatic req_type make_req(input mode_type m, input int unsigned s,
                                        input logic [31:0] v);
      req_type r;
      r.mode = m;
      r.slot = s[PW-1:0];
      r.priority_req = v;
      return r;
   endfunction

   // random value biased toward duplicates and extremes
   function automatic logic [31:0] rand_prio();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 15) - 8;
         default: return $urandom();
      endcase
   endfunction

   int unsigned model_count = 0;

   task automatic queue_req(input req_type r);
      pending_reqs.push_back(r);
      case (mode_type'(r.mode))
         MODE_INSERT: if (model_count < CAP) model_count++;
         MODE_EXTRACT: if (model_count > 0) model_count--;
         MODE_REMOVE: if (r.slot != 0 && r.slot <= model_count) model_count--;
         default: ;
      endcase
   endtask

   function automatic int unsigned rand_slot(input int unsigned n);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return n + 1;
         2: return $urandom_range(0, 2047);
         3: return n;
         default: return (n == 0) ? 1 : $urandom_range(1, n);
      endcase
   endfunction

   initial begin
      int unsigned n, target;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: empty-heap errors, extremes, ties, remove and change
      queue_req(make_req(MODE_EXTRACT, 0, 0));
      queue_req(make_req(MODE_REMOVE, 1, 0));
      queue_req(make_req(MODE_CHANGE, 0, 0));
      queue_req(make_req(MODE_INSERT, 0, 32'h80000000));
      queue_req(make_req(MODE_INSERT, 2047, 32'h7fffffff));
      queue_req(make_req(MODE_INSERT, 0, 32'd5));
      queue_req(make_req(MODE_INSERT, 0, 32'd5));
      queue_req(make_req(MODE_INSERT, 0, 32'hffffffff));
      queue_req(make_req(MODE_REMOVE, 0, 0));
      queue_req(make_req(MODE_REMOVE, 6, 0));
      queue_req(make_req(MODE_CHANGE, 4, 32'd5));          // raise to equal its parent, no move
      queue_req(make_req(MODE_CHANGE, 5, 32'h7fffffff));   // raise to tie the root, stops below it
      queue_req(make_req(MODE_CHANGE, 1, 32'h80000000));   // lower from root
      queue_req(make_req(MODE_REMOVE, 4, 0));
      queue_req(make_req(MODE_REMOVE, 1, 0));
      queue_req(make_req(MODE_EXTRACT, 2047, 32'hffffffff));
      queue_req(make_req(MODE_EXTRACT, 0, 0));
      queue_req(make_req(MODE_EXTRACT, 0, 0));
      queue_req(make_req(MODE_EXTRACT, 0, 0));

      // fill to capacity once, under a long receiver hold-off
      wait (pending_reqs.size() == 0);
      hold_start = 1'b1;
      while (model_count < CAP) queue_req(make_req(MODE_INSERT, $urandom_range(0, 2047),
                                                   rand_prio()));
      queue_req(make_req(MODE_INSERT, 0, 32'd1));          // full
      queue_req(make_req(MODE_CHANGE, CAP, 32'h7fffffff));
      queue_req(make_req(MODE_REMOVE, CAP, 0));
      queue_req(make_req(MODE_CHANGE, CAP + 1, 0));

      // random mix around a wandering size on a deep heap
      for (int i = 0; i < 120; i++) begin
         if (i % 30 == 0) target = $urandom_range(0, CAP);
         n = model_count;
         case ($urandom_range(0, 7))
            0, 1: queue_req(make_req((n < target) ? MODE_INSERT : MODE_EXTRACT,
                                     $urandom_range(0, 2047), rand_prio()));
            2: queue_req(make_req(MODE_INSERT, $urandom_range(0, 2047), rand_prio()));
            3: queue_req(make_req(MODE_EXTRACT, $urandom_range(0, 2047), $urandom()));
            4, 5: queue_req(make_req(MODE_CHANGE, rand_slot(n), rand_prio()));
            default: queue_req(make_req(MODE_REMOVE, rand_slot(n), $urandom()));
         endcase
      end

      wait (pending_reqs.size() == 0 && !req_valid);
      stim_done = 1'b1;
      wait (expected_rsps.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule

[binary_max_heap_queue.f]
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_ram.sv
rtl/core/binary_max_heap_queue.sv
tb/sv/binary_max_heap_queue_tb.sv
